// File: hw/rtl/cpcr_pkg.sv
// Shared widths, side-band record and output arithmetic for the circle pair collision block.
package cpcr_pkg;

  localparam int PosW   = 20;
  localparam int SpdW   = 16;
  localparam int RadW   = 19;
  localparam int DiffW  = 21;
  localparam int DistW  = 42;
  localparam int DenW   = DistW + 1;
  localparam int NumW   = 62;
  localparam int QuoW   = 17;
  localparam int Lanes  = 4;

  typedef struct packed {
    logic                   hit;
    logic                   refl;
    logic [Lanes-1:0]       neg;
    logic signed [SpdW-1:0] vax;
    logic signed [SpdW-1:0] vay;
    logic signed [SpdW-1:0] vbx;
    logic signed [SpdW-1:0] vby;
  } side_t;

  typedef logic [NumW-1:0] num_t;
  typedef logic [QuoW-1:0] quo_t;

  // If refl is set, applies the rounded correction and clamps to Q8.8; else returns v.
  function automatic logic signed [SpdW-1:0] reflect_sat(
    input logic signed [SpdW-1:0] v,
    input quo_t                   q,
    input logic                   neg,
    input logic                   refl
  );
    logic signed [QuoW+1:0] qs;
    logic signed [QuoW+1:0] corr;
    logic signed [QuoW+1:0] val;
    begin
      qs   = signed'({2'b00, q});
      corr = neg ? -qs : qs;
      val  = {{(QuoW+2-SpdW){v[SpdW-1]}}, v} - corr;
      if (!refl) begin
        reflect_sat = v;
      end else if (val > (QuoW+2)'(32767)) begin
        reflect_sat = 16'sh7fff;
      end else if (val < -(QuoW+2)'(32768)) begin
        reflect_sat = 16'sh8000;
      end else begin
        reflect_sat = val[SpdW-1:0];
      end
    end
  endfunction

endpackage

// File: hw/rtl/cpcr_front.sv
// Five-stage front end: differences, products, distance test, dot products and divider operands.
module cpcr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic signed [cpcr_pkg::PosW-1:0] cax,
  input  logic signed [cpcr_pkg::PosW-1:0] cay,
  input  logic signed [cpcr_pkg::PosW-1:0] cbx,
  input  logic signed [cpcr_pkg::PosW-1:0] cby,
  input  logic signed [cpcr_pkg::SpdW-1:0] vax,
  input  logic signed [cpcr_pkg::SpdW-1:0] vay,
  input  logic signed [cpcr_pkg::SpdW-1:0] vbx,
  input  logic signed [cpcr_pkg::SpdW-1:0] vby,
  input  logic [cpcr_pkg::RadW-1:0]        ra,
  input  logic [cpcr_pkg::RadW-1:0]        rb,
  output logic                             out_vld,
  output cpcr_pkg::side_t                  side,
  output cpcr_pkg::num_t                   num [cpcr_pkg::Lanes],
  output logic [cpcr_pkg::DenW-1:0]        den
);

  logic [4:0] vld_r;

  logic signed [20:0] dx1_r, dy1_r;
  logic [19:0]        rs1_r;
  logic signed [15:0] v1_r [4];

  logic [40:0]        dxx2_r, dyy2_r;
  logic [39:0]        rsq2_r;
  logic signed [36:0] pr2_r [4];
  logic signed [20:0] dx2_r, dy2_r;
  logic signed [15:0] v2_r [4];

  logic [41:0]        d23_r;
  logic               hit3_r;
  logic signed [37:0] dota3_r, dotb3_r;
  logic signed [20:0] dx3_r, dy3_r;
  logic signed [15:0] v3_r [4];

  logic signed [58:0] p4_r [4];
  logic [41:0]        d24_r;
  logic               hit4_r;
  logic signed [15:0] v4_r [4];

  cpcr_pkg::side_t    side5_r;
  cpcr_pkg::num_t     num5_r [4];
  logic [42:0]        den5_r;

  logic signed [41:0] sqx, sqy;
  logic signed [36:0] pr_nxt [4];
  logic [41:0]        d2_nxt;
  logic signed [58:0] p_nxt [4];
  logic signed [59:0] nm [4];
  logic [59:0]        mag [4];
  cpcr_pkg::side_t    side_nxt;
  cpcr_pkg::num_t     num_nxt [4];

  always_comb begin
    sqx = dx1_r * dx1_r;
    sqy = dy1_r * dy1_r;
    pr_nxt[0] = v1_r[0] * dx1_r;
    pr_nxt[1] = v1_r[1] * dy1_r;
    pr_nxt[2] = v1_r[2] * dx1_r;
    pr_nxt[3] = v1_r[3] * dy1_r;
    d2_nxt = {1'b0, dxx2_r} + {1'b0, dyy2_r};
    p_nxt[0] = dota3_r * dx3_r;
    p_nxt[1] = dota3_r * dy3_r;
    p_nxt[2] = dotb3_r * dx3_r;
    p_nxt[3] = dotb3_r * dy3_r;
    side_nxt.hit  = hit4_r;
    side_nxt.refl = hit4_r && (d24_r != '0);
    side_nxt.vax  = v4_r[0];
    side_nxt.vay  = v4_r[1];
    side_nxt.vbx  = v4_r[2];
    side_nxt.vby  = v4_r[3];
    for (int i = 0; i < 4; i++) begin
      nm[i]           = {p4_r[i], 1'b0};
      side_nxt.neg[i] = nm[i][59];
      mag[i]          = nm[i][59] ? 60'(-nm[i]) : 60'(nm[i]);
      num_nxt[i]      = {1'b0, mag[i], 1'b0} + {20'b0, d24_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r   <= {cbx[19], cbx} - {cax[19], cax};
      dy1_r   <= {cby[19], cby} - {cay[19], cay};
      rs1_r   <= {1'b0, ra} + {1'b0, rb};
      v1_r[0] <= vax;
      v1_r[1] <= vay;
      v1_r[2] <= vbx;
      v1_r[3] <= vby;

      dxx2_r <= sqx[40:0];
      dyy2_r <= sqy[40:0];
      rsq2_r <= rs1_r * rs1_r;
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
      pr2_r  <= pr_nxt;
      v2_r   <= v1_r;

      d23_r   <= d2_nxt;
      hit3_r  <= d2_nxt <= {2'b00, rsq2_r};
      dota3_r <= {pr2_r[0][36], pr2_r[0]} + {pr2_r[1][36], pr2_r[1]};
      dotb3_r <= {pr2_r[2][36], pr2_r[2]} + {pr2_r[3][36], pr2_r[3]};
      dx3_r   <= dx2_r;
      dy3_r   <= dy2_r;
      v3_r    <= v2_r;

      p4_r   <= p_nxt;
      d24_r  <= d23_r;
      hit4_r <= hit3_r;
      v4_r   <= v3_r;

      side5_r <= side_nxt;
      num5_r  <= num_nxt;
      den5_r  <= {d24_r, 1'b0};
    end
  end

  assign out_vld = vld_r[4];
  assign side    = side5_r;
  assign num     = num5_r;
  assign den     = den5_r;

endmodule

// File: hw/rtl/cpcr_div.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes sharing one denominator.
module cpcr_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  cpcr_pkg::side_t                  in_side,
  input  cpcr_pkg::num_t                   in_num [cpcr_pkg::Lanes],
  input  logic [cpcr_pkg::DenW-1:0]        in_den,
  output logic                             out_vld,
  output cpcr_pkg::side_t                  out_side,
  output cpcr_pkg::quo_t                   out_quo [cpcr_pkg::Lanes]
);

  localparam int QW = cpcr_pkg::QuoW;
  localparam int NW = cpcr_pkg::NumW;
  localparam int DW = cpcr_pkg::DenW;
  localparam int LN = cpcr_pkg::Lanes;

  logic [QW-1:0]   vld_r;
  cpcr_pkg::side_t side_r [QW];
  logic [DW-1:0]   den_r  [QW];
  cpcr_pkg::num_t  rem_r  [QW][LN];
  cpcr_pkg::quo_t  quo_r  [QW][LN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], in_vld};
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    cpcr_pkg::side_t side_in;
    logic [DW-1:0]   den_in;
    cpcr_pkg::num_t  rem_in [LN];
    cpcr_pkg::quo_t  quo_in [LN];
    cpcr_pkg::num_t  dsh;

    if (s == 0) begin : g_first
      assign side_in = in_side;
      assign den_in  = in_den;
      assign rem_in  = in_num;
      always_comb begin
        for (int l = 0; l < LN; l++) begin
          quo_in[l] = '0;
        end
      end
    end else begin : g_rest
      assign side_in = side_r[s-1];
      assign den_in  = den_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign quo_in  = quo_r[s-1];
    end

    assign dsh = {{(NW-DW){1'b0}}, den_in} << K;

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_in;
        den_r[s]  <= den_in;
        for (int l = 0; l < LN; l++) begin
          if (rem_in[l] >= dsh) begin
            rem_r[s][l] <= rem_in[l] - dsh;
            quo_r[s][l] <= quo_in[l] | (QW'(1) << K);
          end else begin
            rem_r[s][l] <= rem_in[l];
            quo_r[s][l] <= quo_in[l];
          end
        end
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_side = side_r[QW-1];
  assign out_quo  = quo_r[QW-1];

endmodule

// File: hw/rtl/circle_pair_collision_reflect.sv
// Top level of the circle pair collision and velocity reflection pipeline.
// Usage:
// The input channel takes one circle pair per transaction: both centres (Q12.8),
// both velocities (Q8.8) and both radii. The result channel delivers one transaction
// per pair, in order: the hit flag and the four new velocity components, saturated.
// A transaction is taken when valid is high and stall is low.
// The pipeline has five front-end stages (differences, squares and products,
// distance test and dot products, numerators, divider operands), seventeen stages of
// the restoring divider (one quotient bit each) and one output stage that applies the
// rounded correction and clamps the result.
// Throughput is one pair per cycle while the receiver does not stall a waiting result.
// Reset clears every valid bit; the pipeline is empty afterwards and payload
// registers are left as they are.
// While the receiver stalls a waiting result, the whole pipeline holds and in_stall
// is raised, so nothing is lost or repeated; when no result is waiting the pipeline
// keeps moving whatever out_stall says.
module circle_pair_collision_reflect (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [19:0]  in_centre_a_x,
  input  logic signed [19:0]  in_centre_a_y,
  input  logic signed [19:0]  in_centre_b_x,
  input  logic signed [19:0]  in_centre_b_y,
  input  logic signed [15:0]  in_speed_a_x,
  input  logic signed [15:0]  in_speed_a_y,
  input  logic signed [15:0]  in_speed_b_x,
  input  logic signed [15:0]  in_speed_b_y,
  input  logic [18:0]         in_radius_a,
  input  logic [18:0]         in_radius_b,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic signed [15:0]  out_new_speed_a_x,
  output logic signed [15:0]  out_new_speed_a_y,
  output logic signed [15:0]  out_new_speed_b_x,
  output logic signed [15:0]  out_new_speed_b_y
);

  logic                          en;
  logic                          fr_vld;
  cpcr_pkg::side_t               fr_side;
  cpcr_pkg::num_t                fr_num [cpcr_pkg::Lanes];
  logic [cpcr_pkg::DenW-1:0]     fr_den;
  logic                          dv_vld;
  cpcr_pkg::side_t               dv_side;
  cpcr_pkg::quo_t                dv_quo [cpcr_pkg::Lanes];

  logic                          out_valid_r;
  logic                          hit_r;
  logic signed [15:0]            nax_r, nay_r, nbx_r, nby_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  cpcr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .cax     (in_centre_a_x),
    .cay     (in_centre_a_y),
    .cbx     (in_centre_b_x),
    .cby     (in_centre_b_y),
    .vax     (in_speed_a_x),
    .vay     (in_speed_a_y),
    .vbx     (in_speed_b_x),
    .vby     (in_speed_b_y),
    .ra      (in_radius_a),
    .rb      (in_radius_b),
    .out_vld (fr_vld),
    .side    (fr_side),
    .num     (fr_num),
    .den     (fr_den)
  );

  cpcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_side  (fr_side),
    .in_num   (fr_num),
    .in_den   (fr_den),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .out_quo  (dv_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= dv_side.hit;
      nax_r <= cpcr_pkg::reflect_sat(dv_side.vax, dv_quo[0], dv_side.neg[0], dv_side.refl);
      nay_r <= cpcr_pkg::reflect_sat(dv_side.vay, dv_quo[1], dv_side.neg[1], dv_side.refl);
      nbx_r <= cpcr_pkg::reflect_sat(dv_side.vbx, dv_quo[2], dv_side.neg[2], dv_side.refl);
      nby_r <= cpcr_pkg::reflect_sat(dv_side.vby, dv_quo[3], dv_side.neg[3], dv_side.refl);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_new_speed_a_x = nax_r;
  assign out_new_speed_a_y = nay_r;
  assign out_new_speed_b_x = nbx_r;
  assign out_new_speed_b_y = nby_r;

endmodule
